// ----- sv/yuyv_pkg.sv -----
// Shared types and fixed-point constants of the YUYV to BGR converter.
package yuyv_pkg;

   localparam int FRAC_BITS = 14;

   localparam int COEF_W = FRAC_BITS + 3;
   localparam int PROD_W = FRAC_BITS + 10;
   localparam int SUM_W  = FRAC_BITS + 12;

   localparam logic [7:0] LUMA_MIN   = 8'd16;
   localparam logic [7:0] LUMA_MAX   = 8'd235;
   localparam logic [7:0] CHROMA_MIN = 8'd16;
   localparam logic [7:0] CHROMA_MAX = 8'd240;
   localparam logic [7:0] CHROMA_MID = 8'd128;

   localparam longint K_LUMA_VAL = ((64'd255 << FRAC_BITS) + 64'd219 / 2) / 64'd219;
   localparam longint K_R_CR_VAL =
      ((64'd178054 << FRAC_BITS) + 64'd112000 / 2) / 64'd112000;
   localparam longint K_G_CB_VAL =
      ((64'd43688 << FRAC_BITS) + 64'd112000 / 2) / 64'd112000;
   localparam longint K_G_CR_VAL =
      ((64'd90678 << FRAC_BITS) + 64'd112000 / 2) / 64'd112000;
   localparam longint K_B_CB_VAL =
      ((64'd225044 << FRAC_BITS) + 64'd112000 / 2) / 64'd112000;

   localparam logic signed [COEF_W-1:0] K_LUMA = COEF_W'(K_LUMA_VAL);
   localparam logic signed [COEF_W-1:0] K_R_CR = COEF_W'(K_R_CR_VAL);
   localparam logic signed [COEF_W-1:0] K_G_CB = COEF_W'(K_G_CB_VAL);
   localparam logic signed [COEF_W-1:0] K_G_CR = COEF_W'(K_G_CR_VAL);
   localparam logic signed [COEF_W-1:0] K_B_CB = COEF_W'(K_B_CB_VAL);

   typedef struct packed {
      logic [7:0] luma_first;
      logic [7:0] chroma_blue;
      logic [7:0] luma_second;
      logic [7:0] chroma_red;
      logic       last_of_frame;
   } yuyv_req_type;

   typedef struct packed {
      logic [7:0] blue_first;
      logic [7:0] green_first;
      logic [7:0] red_first;
      logic [7:0] blue_second;
      logic [7:0] green_second;
      logic [7:0] red_second;
      logic       end_of_frame;
   } yuyv_rsp_type;

   typedef struct packed {
      logic mul;
      logic sum;
      logic out;
   } yuyv_adv_type;

   typedef struct packed {
      logic signed [PROD_W-1:0] red_cr;
      logic signed [PROD_W-1:0] green_cb;
      logic signed [PROD_W-1:0] green_cr;
      logic signed [PROD_W-1:0] blue_cb;
   } yuyv_chroma_type;

endpackage

// ----- sv/yuyv_pixel.sv -----
// Luma scaling, channel sums and output clamping for one pixel.
module yuyv_pixel
   import yuyv_pkg::*;
(
   input  logic            clock,
   input  yuyv_adv_type    adv,
   input  logic [7:0]      luma_off,
   input  yuyv_chroma_type chroma,
   output logic [7:0]      blue,
   output logic [7:0]      green,
   output logic [7:0]      red
);

   logic signed [PROD_W-1:0] luma_scaled_ff, luma_scaled_in;
   logic signed [SUM_W-1:0]  blue_sum_ff, blue_sum_in;
   logic signed [SUM_W-1:0]  green_sum_ff, green_sum_in;
   logic signed [SUM_W-1:0]  red_sum_ff, red_sum_in;
   logic [7:0]               blue_ff, green_ff, red_ff;

   function automatic logic [7:0] to_channel(logic signed [SUM_W-1:0] v);
      logic [7:0] q;
      if (v[SUM_W-1]) begin
         q = 8'd0;
      end else if (|v[SUM_W-2:FRAC_BITS+8]) begin
         q = 8'd255;
      end else begin
         q = v[FRAC_BITS+7:FRAC_BITS];
      end
      return q;
   endfunction

   assign luma_scaled_in = PROD_W'($signed({1'b0, luma_off})) * PROD_W'(K_LUMA);

   assign red_sum_in   = SUM_W'(luma_scaled_ff) + SUM_W'(chroma.red_cr);
   assign green_sum_in = SUM_W'(luma_scaled_ff) - SUM_W'(chroma.green_cb)
                         - SUM_W'(chroma.green_cr);
   assign blue_sum_in  = SUM_W'(luma_scaled_ff) + SUM_W'(chroma.blue_cb);

   always_ff @(posedge clock) begin
      if (adv.mul) begin
         luma_scaled_ff <= luma_scaled_in;
      end
      if (adv.sum) begin
         blue_sum_ff  <= blue_sum_in;
         green_sum_ff <= green_sum_in;
         red_sum_ff   <= red_sum_in;
      end
      if (adv.out) begin
         blue_ff  <= to_channel(blue_sum_ff);
         green_ff <= to_channel(green_sum_ff);
         red_ff   <= to_channel(red_sum_ff);
      end
   end

   assign blue  = blue_ff;
   assign green = green_ff;
   assign red   = red_ff;

endmodule

// ----- sv/yuyv_to_bgr_converter.sv -----
// Top level of the YUYV 4:2:2 to BGR converter, a four-stage pipeline.
//
//   Channel  Ports                                  Carries
//   request  req_valid, req_stall, req_payload      Y0, Cb, Y1, Cr and frame end
//   result   rsp_valid, rsp_stall, rsp_payload      two BGR pixels and frame end
//
// One macropixel enters per clock while req_stall is low; each request passes
// through the clamp, multiply, sum and saturate stages in that order.
// Reset clears only the stage valid bits; the data registers are not reset.
// Each stage holds while the stage after it is full and held, so a stall on
// the result side fills the empty stages before it reaches req_stall.
module yuyv_to_bgr_converter
   import yuyv_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  yuyv_req_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output yuyv_rsp_type rsp_payload
);

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic adv1, adv2, adv3, adv4;

   logic [7:0]        luma0_ff, luma1_ff;
   logic signed [7:0] cb_ff, cr_ff;
   logic              last1_ff, last2_ff, last3_ff, last4_ff;

   yuyv_chroma_type chroma_ff, chroma_in;
   yuyv_adv_type    adv;

   function automatic logic [7:0] luma_offset(logic [7:0] b);
      logic [7:0] r;
      priority if (b < LUMA_MIN) begin
         r = 8'd0;
      end else if (b > LUMA_MAX) begin
         r = LUMA_MAX - LUMA_MIN;
      end else begin
         r = b - LUMA_MIN;
      end
      return r;
   endfunction

   function automatic logic signed [7:0] chroma_offset(logic [7:0] b);
      logic [7:0] c;
      priority if (b < CHROMA_MIN) begin
         c = CHROMA_MIN;
      end else if (b > CHROMA_MAX) begin
         c = CHROMA_MAX;
      end else begin
         c = b;
      end
      return $signed(c - CHROMA_MID);
   endfunction

   assign adv4 = !v4_ff || !rsp_stall;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_stall = !adv1;

   assign adv.mul = adv2;
   assign adv.sum = adv3;
   assign adv.out = adv4;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
      end
   end

   assign chroma_in.red_cr   = PROD_W'(cr_ff) * PROD_W'(K_R_CR);
   assign chroma_in.green_cb = PROD_W'(cb_ff) * PROD_W'(K_G_CB);
   assign chroma_in.green_cr = PROD_W'(cr_ff) * PROD_W'(K_G_CR);
   assign chroma_in.blue_cb  = PROD_W'(cb_ff) * PROD_W'(K_B_CB);

   always_ff @(posedge clock) begin
      if (adv1) begin
         luma0_ff <= luma_offset(req_payload.luma_first);
         luma1_ff <= luma_offset(req_payload.luma_second);
         cb_ff    <= chroma_offset(req_payload.chroma_blue);
         cr_ff    <= chroma_offset(req_payload.chroma_red);
         last1_ff <= req_payload.last_of_frame;
      end
      if (adv2) begin
         chroma_ff <= chroma_in;
         last2_ff  <= last1_ff;
      end
      if (adv3) begin
         last3_ff <= last2_ff;
      end
      if (adv4) begin
         last4_ff <= last3_ff;
      end
   end

   yuyv_pixel u_pixel_first (
      .clock    (clock),
      .adv      (adv),
      .luma_off (luma0_ff),
      .chroma   (chroma_ff),
      .blue     (rsp_payload.blue_first),
      .green    (rsp_payload.green_first),
      .red      (rsp_payload.red_first)
   );

   yuyv_pixel u_pixel_second (
      .clock    (clock),
      .adv      (adv),
      .luma_off (luma1_ff),
      .chroma   (chroma_ff),
      .blue     (rsp_payload.blue_second),
      .green    (rsp_payload.green_second),
      .red      (rsp_payload.red_second)
   );

   assign rsp_payload.end_of_frame = last4_ff;
   assign rsp_valid = v4_ff;

endmodule

// ----- sv/yuyv_checker.sv -----
// Port-level checks of the YUYV to BGR converter and their binding.
module yuyv_checker
   import yuyv_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input yuyv_rsp_type rsp_payload
);

   // A stalled result stays valid.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result was dropped");

   // A stalled result keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_payload))
      else $error("stalled result changed");

   // The request side is only held back by a held result.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a held result");

   // With the result side free while it passes the stages, a taken request comes out as a valid result.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
      |=> rsp_valid)
      else $error("result missing after pipeline latency");

endmodule

bind yuyv_to_bgr_converter yuyv_checker u_checker (.*);
